FILE: src/dasg_pkg.sv
// ----------------------------------------------------------------------------
// dasg_pkg: shared types and constants
// Field widths, op codes, sigmoid table and controller/datapath bundles.
// ----------------------------------------------------------------------------
package dasg_pkg;

  localparam int CHANNELS = 1024;
  localparam int CH_W     = $clog2(CHANNELS);
  localparam int CHAN_W   = 10;
  localparam int VAL_W    = 16;

  localparam logic [VAL_W-1:0] DECAY_RESET = 16'd16384;  // 1.0 in Q2.14
  localparam logic [16:0]      SIG_ONE     = 17'd65536;  // 1.0 in Q0.16

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [63:0] EXP_HALF_STEP = 64'd4162825044;
  localparam logic [63:0] EXP_STEP      = 64'd4034748383;

  typedef logic [15:0] sig_tbl_t [256];

  typedef struct packed {
    logic            clr_en;
    logic [CH_W-1:0] clr_addr;
    logic            accept;
    logic            mul;
    logic            add;
    logic            sq;
    logic            gate;
    logic            load_out;
  } dasg_cmd_t;

  typedef struct packed {
    logic out_free;
  } dasg_status_t;

  // Shift-subtract divide, elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Midpoint sigmoid over [-8,8), 16 raw Q8.8 steps per entry.
  function automatic sig_tbl_t build_sig_table();
    sig_tbl_t    t;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] s;
    logic [63:0] m;
    e = EXP_HALF_STEP;
    for (int k = 0; k < 128; k++) begin
      den        = (64'd1 << 32) + e;
      s          = udiv64((64'd1 << 48) + (den >> 1), den);
      m          = 64'd65536 - s;
      t[128 + k] = s[15:0];
      t[127 - k] = m[15:0];
      e          = (e * EXP_STEP + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam sig_tbl_t SIG_TABLE = build_sig_table();

endpackage

FILE: src/dasg_in_if.sv
// ----------------------------------------------------------------------------
// dasg_in_if: input item channel
// Valid/ready channel carrying op, channel and value.
// ----------------------------------------------------------------------------
interface dasg_in_if;
  import dasg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [CHAN_W-1:0]        channel;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, op, channel, value, input ready);
  modport sink   (input valid, op, channel, value, output ready);
endinterface

FILE: src/dasg_out_if.sv
// ----------------------------------------------------------------------------
// dasg_out_if: result channel
// Valid/ready channel carrying channel_out, hidden, gated and saturated.
// ----------------------------------------------------------------------------
interface dasg_out_if;
  import dasg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CHAN_W-1:0]        channel_out;
  logic signed [VAL_W-1:0]  hidden;
  logic signed [VAL_W-1:0]  gated;
  logic                     saturated;

  modport source (output valid, channel_out, hidden, gated, saturated, input ready);
  modport sink   (input valid, channel_out, hidden, gated, saturated, output ready);
endinterface

FILE: src/dasg_cfg_if.sv
// ----------------------------------------------------------------------------
// dasg_cfg_if: configuration write channel
// Valid/ready channel carrying the decay register write data.
// ----------------------------------------------------------------------------
interface dasg_cfg_if;
  import dasg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: src/dasg_ctrl.sv
// ----------------------------------------------------------------------------
// dasg_ctrl: sequencer
// Clears the hidden store after reset, then walks one item at a time
// through the datapath steps.
// ----------------------------------------------------------------------------
module dasg_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  dasg_pkg::dasg_status_t  status_i,
  output dasg_pkg::dasg_cmd_t     cmd_o
);
  import dasg_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SQ,
    ST_GATE,
    ST_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [CH_W-1:0] clr_q, clr_d;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en   = 1'b1;
        cmd_o.clr_addr = clr_q;
        clr_d          = clr_q + 1'b1;
        if (clr_q == CH_W'(CHANNELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = ST_GATE;
      end
      ST_GATE: begin
        cmd_o.gate = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

endmodule

FILE: src/dasg_dp.sv
// ----------------------------------------------------------------------------
// dasg_dp: datapath
// Hidden store, decay register, the two multiply steps, sigmoid lookup
// and the output register.
// ----------------------------------------------------------------------------
module dasg_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dasg_pkg::dasg_cmd_t                  cmd_i,
  output dasg_pkg::dasg_status_t               status_o,
  input  logic                                 in_op_i,
  input  logic [dasg_pkg::CHAN_W-1:0]          in_channel_i,
  input  logic signed [dasg_pkg::VAL_W-1:0]    in_value_i,
  input  logic                                 cfg_we_i,
  input  logic signed [dasg_pkg::VAL_W-1:0]    cfg_data_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [dasg_pkg::CHAN_W-1:0]          out_channel_o,
  output logic signed [dasg_pkg::VAL_W-1:0]    out_hidden_o,
  output logic signed [dasg_pkg::VAL_W-1:0]    out_gated_o,
  output logic                                 out_saturated_o
);
  import dasg_pkg::*;

  logic [VAL_W-1:0] mem [CHANNELS];

  logic signed [VAL_W-1:0] decay_q;
  logic                    op_q;
  logic [CHAN_W-1:0]       ch_q;
  logic signed [VAL_W-1:0] val_q;
  logic                    in_range_q;
  logic [VAL_W-1:0]        rd_q;
  logic signed [31:0]      prod1_q;
  logic signed [VAL_W-1:0] h_q, h_d;
  logic                    sath_q, sath_d;
  logic [30:0]             sq_q;
  logic [16:0]             sig_q, sig_d;
  logic [47:0]             prod2_q;
  logic                    out_valid_q;

  logic signed [VAL_W-1:0] old;
  logic signed [32:0]      p_rnd;
  logic signed [18:0]      scaled;
  logic signed [19:0]      sum;
  logic [VAL_W-1:0]        mag;
  logic [31:0]             sq_full;
  logic signed [VAL_W-1:0] h_bias;
  logic [47:0]             g_rnd;
  logic [23:0]             g_hi;
  logic [VAL_W-1:0]        g_val;
  logic                    g_clip;
  logic                    in_range;

  assign in_range = ({1'b0, in_channel_i} < (CHAN_W + 1)'(CHANNELS));
  assign old      = in_range_q ? $signed(rd_q) : '0;

  // h = x + round(decay * h_old), clipped
  assign p_rnd  = {prod1_q[31], prod1_q} + 33'sd8192;
  assign scaled = p_rnd[32:14];
  assign sum    = {{4{val_q[15]}}, val_q} + {scaled[18], scaled};

  always_comb begin
    if (op_q == OP_LOAD) begin
      h_d    = val_q;
      sath_d = 1'b0;
    end else if (sum > 20'sd32767) begin
      h_d    = 16'sh7fff;
      sath_d = 1'b1;
    end else if (sum < -20'sd32768) begin
      h_d    = -16'sh8000;
      sath_d = 1'b1;
    end else begin
      h_d    = sum[15:0];
      sath_d = 1'b0;
    end
  end

  assign mag     = h_q[15] ? VAL_W'(-h_q) : h_q;
  assign sq_full = 32'(mag) * 32'(mag);
  assign h_bias  = h_q + 16'sd2048;

  always_comb begin
    if (h_q < -16'sd2048) begin
      sig_d = '0;
    end else if (h_q >= 16'sd2048) begin
      sig_d = SIG_ONE;
    end else begin
      sig_d = {1'b0, SIG_TABLE[h_bias[11:4]]};
    end
  end

  assign g_rnd  = prod2_q + 48'd8388608;
  assign g_hi   = g_rnd[47:24];
  assign g_clip = (g_hi > 24'd32767);
  assign g_val  = g_clip ? 16'h7fff : g_hi[15:0];

  // store: clear sweep, read on accept, write back after the add step
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      mem[cmd_i.clr_addr] <= '0;
    end else if (cmd_i.add && in_range_q) begin
      mem[ch_q[CH_W-1:0]] <= h_d;
    end
    if (cmd_i.accept) begin
      rd_q <= mem[in_channel_i[CH_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= in_op_i;
      ch_q       <= in_channel_i;
      val_q      <= in_value_i;
      in_range_q <= in_range;
    end
    if (cmd_i.mul) begin
      prod1_q <= decay_q * old;
    end
    if (cmd_i.add) begin
      h_q    <= h_d;
      sath_q <= sath_d;
    end
    if (cmd_i.sq) begin
      sq_q  <= sq_full[30:0];
      sig_q <= sig_d;
    end
    if (cmd_i.gate) begin
      prod2_q <= 48'(sq_q) * 48'(sig_q);
    end
    if (cmd_i.load_out) begin
      out_channel_o   <= ch_q;
      out_hidden_o    <= h_q;
      out_gated_o     <= (op_q == OP_LOAD) ? '0 : $signed(g_val);
      out_saturated_o <= (op_q == OP_LOAD) ? 1'b0 : (sath_q | g_clip);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q     <= DECAY_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        decay_q <= cfg_data_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

FILE: src/decay_accumulate_self_gate_top.sv
// ----------------------------------------------------------------------------
// decay_accumulate_self_gate_top: leaky integrator with squared-SiLU gate
// Per-channel hidden state h = x + decay*h_old with y = h*h*sigmoid(h).
// ----------------------------------------------------------------------------
// After reset the block zeroes the hidden store, one entry per cycle;
// in_i.ready stays low until that pass is done, while decay writes on
// cfg_i are taken at any time. An item then goes through these steps
// from transfer to result: the store read on transfer, the decay multiply,
// the round/add/clip with write-back, the square and sigmoid lookup, the
// gate multiply, and the load of the output register. One sequencer walks
// each item through the shared datapath, so the next item is taken once
// the last one is loaded, which waits while out_o holds an untaken result.
// The output register holds a finished result while the next item is
// already being worked on. A load item (op = 1) writes value straight into
// the store and returns it with gated and saturated cleared. All data is
// Q8.8; decay is Q2.14 and resets to 1.0, which gives pure accumulation.
// ----------------------------------------------------------------------------
module decay_accumulate_self_gate_top (
  input logic       clk_i,
  input logic       rst_ni,
  dasg_in_if.sink   in_i,
  dasg_out_if.source out_o,
  dasg_cfg_if.sink  cfg_i
);
  import dasg_pkg::*;

  dasg_cmd_t    cmd;
  dasg_status_t status;

  // decay register takes a write every cycle
  assign cfg_i.ready = 1'b1;

  dasg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dasg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_op_i         (in_i.op),
    .in_channel_i    (in_i.channel),
    .in_value_i      (in_i.value),
    .cfg_we_i        (cfg_i.valid),
    .cfg_data_i      (cfg_i.data),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_channel_o   (out_o.channel_out),
    .out_hidden_o    (out_o.hidden),
    .out_gated_o     (out_o.gated),
    .out_saturated_o (out_o.saturated)
  );

  // one item in flight: a transfer closes the input until the result is loaded
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while an item is in flight");

  // gate is h*h*sigmoid(h), never negative
  a_gated_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !out_o.gated[15])
    else $error("negative gated value");

  // a clip flag must come with a value at a rail
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      out_o.hidden == 16'sh7fff || out_o.hidden == -16'sh8000 ||
      out_o.gated == 16'sh7fff)
    else $error("saturated set without a clipped value");

endmodule

FILE: verif/decay_accumulate_self_gate_top_tb.sv
// ----------------------------------------------------------------------------
// decay_accumulate_self_gate_top_tb: self-checking bench for the leaky
// integrator with squared-SiLU gate
// Sends step and load transfers on in_i and keeps a per-channel hidden value
// mirror to work out hidden, gated and saturated for every transfer. Results
// on out_o are checked in order. Phases run with different decay settings
// and with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module decay_accumulate_self_gate_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dasg_pkg::*;

  typedef struct packed {
    logic                    op;
    logic [CHAN_W-1:0]       channel;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]       channel_out;
    logic signed [VAL_W-1:0] hidden;
    logic signed [VAL_W-1:0] gated;
    logic                    saturated;
  } result_t;

  logic clk_i;
  logic rst_ni;

  dasg_in_if  in_if ();
  dasg_out_if out_if ();
  dasg_cfg_if cfg_if ();

  decay_accumulate_self_gate_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // Items waiting to be sent, and results owed by the block, oldest first.
  item_t   items_to_send [$];
  result_t results_due [$];

  // Mirror of the block: hidden store, decay register, sigmoid lookup
  // (unsigned Q0.16, one entry per 16 raw Q8.8 steps over [-8, 8)).
  logic signed [VAL_W-1:0] hidden_mem [CHANNELS];
  logic signed [VAL_W-1:0] decay_q;
  logic [16:0]             sig_lut [256];

  // A few channels that the random part keeps returning to, so that the
  // recurrence runs long enough to grow, decay, flip sign and saturate.
  logic [CHAN_W-1:0] hot_ch [8];

  // Percent of cycles the sender idles / the receiver stalls.
  int idle_pct;
  int stall_pct;
  int mismatches;

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Slowest correct run is the clearing pass plus ~1000 transfers; 1 ms leaves
  // a wide margin.
  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Next-state predictor: one transfer in, one result out, store updated
  // ---------------------------------------------------------------------------
  function automatic result_t step_hidden(item_t it);
    result_t r;
    longint  h_old;
    longint  prod;
    longint  h;
    longint  mag;
    longint  sig;
    longint  g;
    r.channel_out = it.channel;
    r.gated       = '0;
    r.saturated   = 1'b0;
    if (it.op == OP_LOAD) begin
      r.hidden = it.value;
    end else begin
      h_old = (it.channel < CHANNELS) ? longint'(hidden_mem[it.channel]) : 0;
      // Q2.14 * Q8.8, round half up back to Q8.8 (floor after adding half).
      prod = longint'(decay_q) * h_old;
      h    = longint'(it.value) + ((prod + 8192) >>> 14);
      if (h > 32767) begin
        h           = 32767;
        r.saturated = 1'b1;
      end
      if (h < -32768) begin
        h           = -32768;
        r.saturated = 1'b1;
      end
      r.hidden = h[VAL_W-1:0];

      // Off the table: 0 below -8.0, 1.0 at or above 8.0.
      if (h < -2048)
        sig = 0;
      else if (h >= 2048)
        sig = longint'(SIG_ONE);
      else
        sig = longint'(sig_lut[(h + 2048) >>> 4]);
      mag = (h < 0) ? -h : h;
      g   = (mag * mag * sig + (longint'(1) << 23)) >>> 24;
      if (g > 32767) begin
        g           = 32767;
        r.saturated = 1'b1;
      end
      r.gated = g[VAL_W-1:0];
    end
    if (it.channel < CHANNELS)
      hidden_mem[it.channel] = r.hidden;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: feeds in_i from items_to_send; a held item stays put until its
  // transfer, so gaps only fall between items.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    item_t on_bus;
    item_t nxt;
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.op      <= OP_STEP;
      in_if.channel <= '0;
      in_if.value   <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        on_bus.op      = in_if.op;
        on_bus.channel = in_if.channel;
        on_bus.value   = in_if.value;
        results_due.push_back(step_hidden(on_bus));
      end
      if (!in_if.valid || in_if.ready) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt           = items_to_send.pop_front();
          in_if.valid   <= 1'b1;
          in_if.op      <= nxt.op;
          in_if.channel <= nxt.channel;
          in_if.value   <= nxt.value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure on out_o, every result transfer checked
  // against the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (results_due.size() == 0) begin
          flag_mismatch("result with nothing owed, channel", out_if.channel_out, -1);
        end else begin
          want = results_due.pop_front();
          if (out_if.channel_out !== want.channel_out)
            flag_mismatch("channel_out", out_if.channel_out, want.channel_out);
          if (out_if.hidden !== want.hidden)
            flag_mismatch("hidden", out_if.hidden, want.hidden);
          if (out_if.gated !== want.gated)
            flag_mismatch("gated", out_if.gated, want.gated);
          if (out_if.saturated !== want.saturated)
            flag_mismatch("saturated", out_if.saturated, want.saturated);
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(logic op, int ch, int val);
    item_t it;
    it.op      = op;
    it.channel = ch[CHAN_W-1:0];
    it.value   = val[VAL_W-1:0];
    items_to_send.push_back(it);
  endtask

  // Block is idle once every item is sent and every result is back; the
  // trailing wait adds margin before the next phase.
  task automatic wait_drained();
    do
      @(negedge clk_i);
    while (items_to_send.size() != 0 || in_if.valid || results_due.size() != 0);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_decay(logic signed [VAL_W-1:0] d);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= d;
    do
      @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    decay_q = d;
  endtask

  // One random phase: set decay, pick the idling mix, send count items.
  // Most items revisit a few hot channels; values lean small so h stays
  // inside the sigmoid table, with wider and extreme values mixed in.
  task automatic run_phase(logic signed [VAL_W-1:0] d, int send_idle,
                           int recv_stall, int count);
    logic op;
    int   ch;
    int   val;
    int   pick;
    write_decay(d);
    @(negedge clk_i);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(99) < 15) ? OP_LOAD : OP_STEP;
      ch = ($urandom_range(99) < 60) ? int'(hot_ch[$urandom_range(7)])
                                     : int'($urandom_range(CHANNELS - 1));
      pick = $urandom_range(99);
      if (pick < 40)
        val = int'($urandom_range(1023)) - 512;
      else if (pick < 70)
        val = int'($urandom_range(8191)) - 4096;
      else if (pick < 90)
        val = int'($urandom_range(65535)) - 32768;
      else begin
        case ($urandom_range(3))
          0:       val = -32768;
          1:       val = 32767;
          2:       val = 0;
          default: val = -1;
        endcase
      end
      queue_item(op, ch, val);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] s;

    // Known levels on every block input from time zero.
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.op      = OP_STEP;
    in_if.channel = '0;
    in_if.value   = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    mismatches    = 0;

    // Sigmoid at interval midpoints: positive half from e^-(2k+1)/32 in
    // Q0.32, negative half mirrored around 1.0.
    e = EXP_HALF_STEP;
    for (int k = 0; k < 128; k++) begin
      den              = (64'd1 << 32) + e;
      s                = ((64'd1 << 48) + (den >> 1)) / den;
      sig_lut[128 + k] = s[16:0];
      sig_lut[127 - k] = SIG_ONE - s[16:0];
      e                = (e * EXP_STEP + (64'd1 << 31)) >> 32;
    end

    foreach (hidden_mem[i]) hidden_mem[i] = '0;
    decay_q = DECAY_RESET;

    hot_ch[0] = 10'd0;
    hot_ch[1] = 10'd1;
    hot_ch[2] = 10'd2;
    hot_ch[3] = 10'h155;
    hot_ch[4] = 10'h2AA;
    hot_ch[5] = 10'd511;
    hot_ch[6] = 10'd512;
    hot_ch[7] = 10'd1023;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset decay of 1.0 (pure accumulation). The
    // block is still clearing its store; the driver simply waits for ready.
    queue_item(OP_STEP, 0, 0);           // untouched channel reads zero
    queue_item(OP_STEP, 0, 256);         // 1.0, inside the table
    queue_item(OP_STEP, 0, 256);         // back-to-back on one channel
    queue_item(OP_STEP, 0, -1);
    queue_item(OP_LOAD, 1023, 32767);    // load returns value, gated 0
    queue_item(OP_STEP, 1023, 32767);    // hidden clips high
    queue_item(OP_LOAD, 1, -32768);
    queue_item(OP_STEP, 1, -32768);      // hidden clips low, below the table
    queue_item(OP_STEP, 2, -2049);       // just below -8.0: sigmoid 0
    queue_item(OP_STEP, 3, -2048);       // first table entry
    queue_item(OP_STEP, 4, 2047);        // last table entry
    queue_item(OP_STEP, 5, 2048);        // 8.0: sigmoid 1.0
    queue_item(OP_STEP, 6, 32767);       // gated clips, hidden does not
    queue_item(OP_STEP, 7, 1);
    queue_item(OP_STEP, 7, -2);
    queue_item(OP_LOAD, 10'h155, 16'h5555);
    queue_item(OP_STEP, 10'h155, -16'sh5556);
    queue_item(OP_LOAD, 10'h2AA, -21846);
    queue_item(OP_STEP, 10'h2AA, 21845);
    queue_item(OP_STEP, 10'h2AA, 100);
    queue_item(OP_LOAD, 512, 0);
    queue_item(OP_STEP, 512, -32768);
    queue_item(OP_STEP, 511, 0);
    wait_drained();

    // Random phases: every idling mix, decay extremes and ordinary values.
    run_phase(DECAY_RESET, 0, 0, 140);
    run_phase(16'sd32767, 87, 0, 120);
    run_phase(-16'sd32768, 0, 87, 120);
    run_phase(16'sd0, 17, 17, 120);
    run_phase(VAL_W'($urandom_range(65535)), 0, 0, 120);
    run_phase(16'sd15565, 87, 0, 120);       // about 0.95: leaky
    run_phase(-16'sd16384, 0, 87, 120);      // -1.0: sign flip each step
    run_phase(VAL_W'($urandom_range(65535)), 17, 17, 130);

    if (results_due.size() != 0)
      flag_mismatch("results never returned", results_due.size(), 0);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
src/dasg_pkg.sv
src/dasg_in_if.sv
src/dasg_out_if.sv
src/dasg_cfg_if.sv
src/dasg_ctrl.sv
src/dasg_dp.sv
src/decay_accumulate_self_gate_top.sv
verif/decay_accumulate_self_gate_top_tb.sv
